[rtl/core/bat_pkg.sv]
// Shared types and constants for the breakpoint address table.
`timescale 1ns / 1ps
`default_nettype none
package bat_pkg;

	localparam int ADDR_W  = 32;
	localparam int CNT_O_W = 8;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CHECK  = 2'd2
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_RUN  = 1'b1
	} state_t;

	// Per-cycle control broadcast to every cell of the chain
	typedef struct packed {
		logic rot;   // rotation step: cells advance toward the head
		logic keep;  // head word survives and re-enters at the tail
		logic ins;   // append the latched address after the last entry
	} cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/bat_cell.sv]
// One slot of the entry chain: holds a word and takes its neighbor's word on rotation.
`timescale 1ns / 1ps
`default_nettype none
module bat_cell #(
	parameter int DEPTH = 128,
	parameter int IDX   = 0
) (
	input  wire logic                         clk,
	input  wire bat_pkg::cell_ctl_t           ctl,
	input  wire logic [$clog2(DEPTH+1)-1:0]   len,
	input  wire logic [bat_pkg::ADDR_W-1:0]   next_word,
	input  wire logic [bat_pkg::ADDR_W-1:0]   head_word,
	input  wire logic [bat_pkg::ADDR_W-1:0]   ins_word,
	output logic      [bat_pkg::ADDR_W-1:0]   word
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] IDX_C  = CW'(IDX);
	localparam logic [CW-1:0] IDX1_C = CW'(IDX + 1);

	logic [bat_pkg::ADDR_W-1:0] word_q;

	// Append, shift toward head, or take the surviving head word at the tail
	always_ff @(posedge clk) begin
		if (ctl.ins && (len == IDX_C)) begin
			word_q <= ins_word;
		end else if (ctl.rot) begin
			if (IDX1_C < len) begin
				word_q <= next_word;
			end else if ((IDX1_C == len) && ctl.keep) begin
				word_q <= head_word;
			end
		end
	end

	assign word = word_q;

endmodule
`default_nettype wire

[rtl/core/bat_seq.sv]
// Command sequencer: walks the chain once per check or remove and tracks the entry count.
`timescale 1ns / 1ps
`default_nettype none
module bat_seq #(
	parameter int DEPTH = 128
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   cmd,
	input  wire logic [bat_pkg::ADDR_W-1:0]   address,
	input  wire logic [bat_pkg::ADDR_W-1:0]   head_word,
	input  wire logic                         out_free,
	output bat_pkg::cell_ctl_t                ctl,
	output logic      [$clog2(DEPTH+1)-1:0]   len,
	output logic      [bat_pkg::ADDR_W-1:0]   ins_word,
	output logic                              fin,
	output logic                              res_status,
	output logic                              res_hit,
	output logic      [$clog2(DEPTH+1)-1:0]   res_len
);

	localparam int CW = $clog2(DEPTH+1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	bat_pkg::state_t             state_q, state_nxt;
	bat_pkg::cmd_t               cmd_q;
	logic [bat_pkg::ADDR_W-1:0]  addr_q;
	logic [CW-1:0]               steps_q, len_q, len_nxt;
	logic                        hit_q;
	logic                        accept, stepping, match, keep, full, ins;

	// Decode the current step
	always_comb begin
		in_ready = (state_q == bat_pkg::ST_IDLE);
		accept   = in_valid && in_ready;
		stepping = (state_q == bat_pkg::ST_RUN) && (steps_q != '0);
		match    = (head_word == addr_q);
		keep     = !((cmd_q == bat_pkg::CMD_REMOVE) && match);
		full     = (len_q == DEPTH_C);
		fin      = (state_q == bat_pkg::ST_RUN) && (steps_q == '0) && out_free;
		ins      = fin && (cmd_q == bat_pkg::CMD_INSERT) && !full;
		if (ins) begin
			len_nxt = len_q + ONE_C;
		end else if (stepping && !keep) begin
			len_nxt = len_q - ONE_C;
		end else begin
			len_nxt = len_q;
		end
		ctl.rot    = stepping;
		ctl.keep   = keep;
		ctl.ins    = ins;
		res_status = (cmd_q == bat_pkg::CMD_INSERT) && full;
		res_hit    = hit_q;
		res_len    = len_nxt;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bat_pkg::ST_IDLE: begin
				if (accept) state_nxt = bat_pkg::ST_RUN;
			end
			bat_pkg::ST_RUN: begin
				if (fin) state_nxt = bat_pkg::ST_IDLE;
			end
			default: state_nxt = bat_pkg::ST_IDLE;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bat_pkg::ST_IDLE;
			len_q   <= '0;
			steps_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;
			len_q   <= len_nxt;
			if (accept) begin
				hit_q <= 1'b0;
				// walk the live entries only for remove and check
				if ((cmd == bat_pkg::CMD_REMOVE) || (cmd == bat_pkg::CMD_CHECK)) begin
					steps_q <= len_q;
				end else begin
					steps_q <= '0;
				end
			end else if (stepping) begin
				steps_q <= steps_q - ONE_C;
				if ((cmd_q == bat_pkg::CMD_CHECK) && match) hit_q <= 1'b1;
			end
		end
	end

	// Hold the command word while it runs
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= bat_pkg::cmd_t'(cmd);
			addr_q <= address;
		end
	end

	assign len      = len_q;
	assign ins_word = addr_q;

endmodule
`default_nettype wire

[rtl/core/breakpoint_address_table.sv]
// Top level of the breakpoint address table: cell chain, sequencer and result register.
//
//  channel  signals                      direction  payload
//  input    in_valid / in_ready          in         cmd[1:0], address[31:0]
//  output   out_valid / out_ready        out        status, hit, entry_count[7:0]
//
// An insert or an unused command code does not walk the chain; a check or remove
// walks every entry, since the entries rotate through the head of the chain one per
// cycle for the compare. A new word is accepted only once the last command has finished.
// Reset (arst_n low) empties the table; stored words are not cleared.
// A result waits in the output register while the next command runs; a command
// only finishes once the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module breakpoint_address_table #(
	parameter int DEPTH = 128
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   cmd,
	input  wire logic [bat_pkg::ADDR_W-1:0]   address,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              status,
	output logic                              hit,
	output logic      [bat_pkg::CNT_O_W-1:0]  entry_count
);

	localparam int CW = $clog2(DEPTH+1);

	bat_pkg::cell_ctl_t          ctl;
	logic [CW-1:0]               len, res_len;
	logic [bat_pkg::ADDR_W-1:0]  ins_word;
	logic [bat_pkg::ADDR_W-1:0]  words [DEPTH];
	logic                        fin, res_status, res_hit, out_free;
	logic [CW+bat_pkg::CNT_O_W-1:0] len_ext;
	logic                        out_valid_q, status_q, hit_q;
	logic [bat_pkg::CNT_O_W-1:0] count_q;

	assign out_free = !out_valid_q || out_ready;
	assign len_ext  = {{bat_pkg::CNT_O_W{1'b0}}, res_len};

	bat_seq #(
		.DEPTH(DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.address    (address),
		.head_word  (words[0]),
		.out_free   (out_free),
		.ctl        (ctl),
		.len        (len),
		.ins_word   (ins_word),
		.fin        (fin),
		.res_status (res_status),
		.res_hit    (res_hit),
		.res_len    (res_len)
	);

	// Chain of entry cells, head at index zero
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [bat_pkg::ADDR_W-1:0] next_word;
		if (i == DEPTH - 1) begin : g_tail
			assign next_word = words[0];
		end else begin : g_mid
			assign next_word = words[i+1];
		end
		bat_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.len       (len),
			.next_word (next_word),
			.head_word (words[0]),
			.ins_word  (ins_word),
			.word      (words[i])
		);
	end

	// Hold the result word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			status_q <= res_status;
			hit_q    <= res_hit;
			count_q  <= len_ext[bat_pkg::CNT_O_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign hit         = hit_q;
	assign entry_count = count_q;

endmodule
`default_nettype wire

[test/tb_breakpoint_address_table.sv]
// Testbench for breakpoint_address_table: directed rows and random phases against a predictor.
`timescale 1ns / 1ps
module tb_breakpoint_address_table;

	localparam int TB_DEPTH       = 128;
	localparam int TOTAL_WORDS    = 1750;
	localparam int WATCHDOG_LIMIT = 20 * (TB_DEPTH + 2) + 200;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic       status;
		logic       hit;
		logic [7:0] count;
	} table_result_t;

	typedef struct packed {
		logic [1:0]    op;
		logic [31:0]   addr;
		logic          typed;
		table_result_t want;
	} directed_row_t;

	typedef enum int {PH_FILL, PH_MIX, PH_DRAIN, PH_CHECKS} phase_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  cmd;
	logic [31:0] address;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic        hit;
	logic [7:0]  entry_count;

	// predictor state: the stored breakpoints in table order
	logic [31:0]   bp_words[$];
	table_result_t pending_results[$];
	directed_row_t directed_rows[$];
	logic [31:0]   addr_pool[16];

	bit send_idle_on;
	bit recv_idle_on;
	int words_sent;
	int error_count;
	int idle_cycles;
	int n_insert, n_refused, n_remove, n_check, n_hit, n_unused, n_full, n_pauses;

	breakpoint_address_table #(
		.DEPTH(TB_DEPTH)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.address    (address),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.hit        (hit),
		.entry_count(entry_count)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// Apply one command to the table copy and return the word it should produce
	function automatic table_result_t apply_command(input logic [1:0] op,
			input logic [31:0] addr);
		table_result_t r;
		logic [31:0]   kept[$];
		r = '0;
		if (op == bat_pkg::CMD_INSERT) begin
			n_insert++;
			if (bp_words.size() >= TB_DEPTH) begin
				r.status = 1'b1;
				n_refused++;
			end else begin
				bp_words.push_back(addr);
				if (bp_words.size() == TB_DEPTH)
					n_full++;
			end
		end else if (op == bat_pkg::CMD_REMOVE) begin
			n_remove++;
			foreach (bp_words[i])
				if (bp_words[i] != addr)
					kept.push_back(bp_words[i]);
			bp_words = kept;
		end else if (op == bat_pkg::CMD_CHECK) begin
			n_check++;
			foreach (bp_words[i])
				if (bp_words[i] == addr)
					r.hit = 1'b1;
			if (r.hit)
				n_hit++;
		end else begin
			n_unused++;
		end
		r.count = 8'(bp_words.size());
		return r;
	endfunction

	// Favor stored and pooled addresses so checks and removes find matches
	function automatic logic [31:0] pick_address();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45 && bp_words.size() != 0)
			return bp_words[$urandom_range(0, bp_words.size() - 1)];
		else if (r < 75)
			return addr_pool[$urandom_range(0, 15)];
		else
			return $urandom;
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [31:0] addr, input logic typed,
			input logic st, input logic h, input logic [7:0] cnt);
		directed_row_t row;
		row.op          = op;
		row.addr        = addr;
		row.typed       = typed;
		row.want.status = st;
		row.want.hit    = h;
		row.want.count  = cnt;
		directed_rows.push_back(row);
	endtask

	// Present one word, hold it until accepted, then record its expected result
	task automatic send_word(input logic [1:0] op, input logic [31:0] addr, input logic typed,
			input table_result_t want);
		int            gap;
		table_result_t model;
		gap = send_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		address  <= addr;
		do @(posedge clk); while (!in_ready);
		model = apply_command(op, addr);
		pending_results.push_back(typed ? want : model);
		words_sent++;
	endtask

	// Drop valid and hold off until every outstanding result has drained
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		n_pauses++;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Result side: random ready gaps, compare each word with the oldest expectation
	initial begin : result_sink
		int            gap;
		table_result_t got;
		table_result_t want;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			gap = recv_idle_on ? $urandom_range(0, 9) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.status = status;
			got.hit    = hit;
			got.count  = entry_count;
			if (pending_results.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result word status=%0d hit=%0d count=%0d",
					$time, got.status, got.hit, got.count);
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status || got.hit !== want.hit ||
						got.count !== want.count) begin
					error_count++;
					$display("%0t: expected st=%0d hit=%0d cnt=%0d, got st=%0d hit=%0d cnt=%0d",
						$time, want.status, want.hit, want.count,
						got.status, got.hit, got.count);
				end
			end
		end
	end

	// Watchdog: count cycles with no word moving on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, idle_cycles, pending_results.size());
			$display("[breakpoint_address_table] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		phase_t     phase;
		logic [1:0] op;
		logic [31:0] addr;
		int         r;
		int         steps;
		int         span;
		int         refused_goal;
		int         refused_seen;
		bit         first_phase;

		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = bat_pkg::CMD_INSERT;
		address      = '0;
		send_idle_on = 1'b1;
		recv_idle_on = 1'b1;
		idle_cycles  = 0;
		words_sent   = 0;
		error_count  = 0;
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < 16; i++)
			addr_pool[i] = $urandom;

		// empty table, address extremes, duplicates, remove-all with compaction,
		// absent remove, unused code
		add_row(bat_pkg::CMD_CHECK,  32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'd0);
		add_row(CMD_UNUSED,          32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_INSERT, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 8'd1);
		add_row(bat_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 8'd2);
		add_row(bat_pkg::CMD_CHECK,  32'h0000_0000, 1'b1, 1'b0, 1'b1, 8'd2);
		add_row(bat_pkg::CMD_CHECK,  32'hFFFF_FFFF, 1'b1, 1'b0, 1'b1, 8'd2);
		add_row(bat_pkg::CMD_CHECK,  32'h8000_0000, 1'b1, 1'b0, 1'b0, 8'd2);
		add_row(bat_pkg::CMD_INSERT, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_INSERT, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_INSERT, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_CHECK,  32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_CHECK,  32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(CMD_UNUSED,          32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_REMOVE, 32'hDEAD_BEEF, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_REMOVE, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_REMOVE, 32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_CHECK,  32'hA5A5_A5A5, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_REMOVE, 32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'd0);
		add_row(bat_pkg::CMD_CHECK,  32'h1234_5678, 1'b0, 1'b0, 1'b0, 8'd0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].addr,
				directed_rows[i].typed, directed_rows[i].want);
		hold_until_drained();

		// random phases: fill to full, mixed traffic, drain, back-to-back checks
		first_phase = 1'b1;
		while (words_sent < TOTAL_WORDS) begin
			r = $urandom_range(0, 9);
			if (first_phase)
				phase = PH_FILL;
			else if (r < 3)
				phase = PH_FILL;
			else if (r < 6)
				phase = PH_MIX;
			else if (r < 8)
				phase = PH_DRAIN;
			else
				phase = PH_CHECKS;
			first_phase  = 1'b0;
			send_idle_on = ($urandom_range(0, 9) < 7);
			recv_idle_on = ($urandom_range(0, 9) < 7);
			case (phase)
				PH_FILL: begin
					refused_goal = $urandom_range(2, 8);
					refused_seen = 0;
					steps        = 0;
					while (refused_seen < refused_goal && steps < TB_DEPTH + 80) begin
						r = $urandom_range(0, 99);
						if (r < 80)
							op = bat_pkg::CMD_INSERT;
						else if (r < 95)
							op = bat_pkg::CMD_CHECK;
						else
							op = bat_pkg::CMD_REMOVE;
						addr = (op == bat_pkg::CMD_REMOVE) ? $urandom : pick_address();
						if (op == bat_pkg::CMD_INSERT && bp_words.size() >= TB_DEPTH)
							refused_seen++;
						send_word(op, addr, 1'b0, '0);
						steps++;
					end
				end
				PH_MIX: begin
					span = $urandom_range(60, 120);
					for (steps = 0; steps < span; steps++) begin
						r = $urandom_range(0, 99);
						if (r < 35)
							op = bat_pkg::CMD_INSERT;
						else if (r < 55)
							op = bat_pkg::CMD_REMOVE;
						else if (r < 95)
							op = bat_pkg::CMD_CHECK;
						else
							op = CMD_UNUSED;
						send_word(op, pick_address(), 1'b0, '0);
					end
				end
				PH_DRAIN: begin
					steps = 0;
					while (bp_words.size() != 0 && steps < 200) begin
						if ($urandom_range(0, 3) == 0)
							send_word(bat_pkg::CMD_CHECK, pick_address(), 1'b0, '0);
						else
							send_word(bat_pkg::CMD_REMOVE,
								bp_words[$urandom_range(0, bp_words.size() - 1)],
								1'b0, '0);
						steps++;
					end
					send_word(bat_pkg::CMD_CHECK, pick_address(), 1'b0, '0);
				end
				default: begin
					send_idle_on = 1'b0;
					span = $urandom_range(30, 60);
					for (steps = 0; steps < span; steps++)
						send_word(bat_pkg::CMD_CHECK, pick_address(), 1'b0, '0);
				end
			endcase
			if ($urandom_range(0, 2) == 0)
				hold_until_drained();
		end

		// let every result land, then watch a while for stray words
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
		repeat (2 * TB_DEPTH + 20) @(posedge clk);

		$display("covered %0d words: %0d inserts (%0d refused when full), %0d removes,",
			words_sent, n_insert, n_refused, n_remove);
		$display("%0d checks (%0d hits), %0d unused codes, %0d fills, %0d drained pauses",
			n_check, n_hit, n_unused, n_full, n_pauses);
		if (error_count == 0)
			$display("[breakpoint_address_table] OK");
		else
			$display("[breakpoint_address_table] ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/bat_pkg.sv
rtl/core/bat_cell.sv
rtl/core/bat_seq.sv
rtl/core/breakpoint_address_table.sv
test/tb_breakpoint_address_table.sv
